### rtl/core/i2c_master_register_access_macros.svh
// ----------------------------------------------------------------------------
// I2C master register access: assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every enabled clock edge.
`define I2CM_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define I2CM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define I2CM_ASSERT(lbl, clk, rstn, cond, msg)
`define I2CM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types, codes and constants of the I2C master slot sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Default depth of the write buffer and largest transfer length.
  localparam int unsigned MAX_LEN_DEF = 16;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 5;

  // Bit counter value that marks the acknowledge bit of a byte.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Command codes carried by each input beat.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Transfer status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ADDR_NACK = 2'd1,
    ST_DATA_NACK = 2'd2
  } status_t;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_HOLD = 4'd1,
    PH_DEVW       = 4'd2,
    PH_REG        = 4'd3,
    PH_DATA       = 4'd4,
    PH_RS1        = 4'd5,
    PH_RS2        = 4'd6,
    PH_RS3        = 4'd7,
    PH_RS4        = 4'd8,
    PH_DEVR       = 4'd9,
    PH_RX         = 4'd10,
    PH_STOP1      = 4'd11,
    PH_STOP2      = 4'd12,
    PH_STOP3      = 4'd13
  } phase_t;

  // One input beat.
  typedef struct packed {
    cmd_t              cmd;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
    logic              sda_in;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              rd_valid;
    logic [BYTE_W-1:0] rd_byte;
    logic              rd_last;
    logic              done_res;
    status_t           status;
  } res_t;

endpackage

### rtl/core/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access
// I2C master that produces one bus timing slot per input beat.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries a command (tick, load write byte, start write,
// start read) plus the sampled SDA level. Every accepted beat yields exactly
// one result beat with the SCL and SDA levels of that slot, busy and done
// flags, any received byte and the status of the latest transfer.
// Load beats fill the write buffer while idle; start beats launch a transfer,
// and tick beats then walk it through its slots. Loads and starts arriving
// during a transfer are dropped and repeat the held line levels.
// The user must write the device address on the cfg channel only while the
// block is idle; the block does not enforce this. A beat passes the input
// register, then the result register. One beat is accepted per cycle unless
// the receiver stalls; the only recurrence is the sequencer state.
// When the receiver stalls, the result and input registers fill and in_ready
// drops; no beat is lost. Reset returns the sequencer to idle with both lines
// released and clears the status and the device address.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_macros.svh"

module i2c_master_register_access #(
  parameter int unsigned MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_length,
  input  logic       in_sda_in,
  // Result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_rd_valid,
  output logic [7:0] out_rd_byte,
  output logic       out_rd_last,
  output logic       out_done_res,
  output logic [1:0] out_status,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import i2cm_pkg::*;

  logic  in_v_r;
  item_t item_r;
  logic  out_v_r;
  res_t  res_r;
  res_t  res;
  logic  advance;
  logic  step;
  logic  in_fire;

  // Pipeline handshake: the pipeline advances when the result register is empty or drains.
  assign advance   = !out_v_r || out_ready;
  assign step      = in_v_r && advance;
  assign in_ready  = !in_v_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (step) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd       <= cmd_t'(in_cmd);
      item_r.reg_addr  <= in_reg_addr;
      item_r.data_byte <= in_data_byte;
      item_r.length    <= in_length;
      item_r.sda_in    <= in_sda_in;
    end
  end

  // Slot sequencer.
  i2cm_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (item_r),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_scl_level = res_r.scl_level;
  assign out_sda_level = res_r.sda_level;
  assign out_busy_res  = res_r.busy_res;
  assign out_rd_valid  = res_r.rd_valid;
  assign out_rd_byte   = res_r.rd_byte;
  assign out_rd_last   = res_r.rd_last;
  assign out_done_res  = res_r.done_res;
  assign out_status    = res_r.status;

  // A received byte is only presented in the middle of a transfer.
  `I2CM_ASSERT(a_rd_in_busy, clk, rst_n, !(out_v_r && out_rd_valid) || out_busy_res, "rd_valid outside a transfer")

  // The done slot releases both lines and ends busy.
  `I2CM_ASSERT(a_done_release, clk, rst_n, !(out_v_r && out_done_res) || (!out_busy_res && out_scl_level && out_sda_level), "done slot does not release the bus")

  // The last-byte mark only travels with a received byte.
  `I2CM_ASSERT(a_last_with_byte, clk, rst_n, !(out_v_r && out_rd_last) || out_rd_valid, "rd_last without rd_valid")

  // A held input beat is neither dropped nor overwritten while the result stalls.
  `I2CM_ASSERT_NEXT(a_input_held, clk, rst_n, in_v_r && !advance, in_v_r && $stable(item_r), "input register lost a beat")

endmodule

### rtl/core/i2cm_seq.sv
// ----------------------------------------------------------------------------
// I2C master slot sequencer
// Holds the transfer state and write buffer, and works out the line levels
// and status of one timing slot per step.
// ----------------------------------------------------------------------------
module i2cm_seq #(
  parameter int unsigned MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  i2cm_pkg::item_t item,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  output i2cm_pkg::res_t  res
);
  import i2cm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // State registers.
  phase_t            phase_r, phase_nxt;
  logic [3:0]        bit_count_r, bit_count_nxt;
  logic [1:0]        sub_slot_r, sub_slot_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0]  load_ptr_r, load_ptr_nxt;
  logic [CNT_W-1:0]  total_len_r, total_len_nxt;
  logic              read_mode_r, read_mode_nxt;
  status_t           last_status_r, last_status_nxt;
  logic              ack_seen_r, ack_seen_nxt;
  logic [BYTE_W-1:0] reg_latch_r, reg_latch_nxt;
  logic              scl_q_r, scl_q_nxt;
  logic              sda_q_r, sda_q_nxt;
  logic [BYTE_W-1:0] dev_addr_r;
  logic [BYTE_W-1:0] wbuf_r [MAX_LEN];

  // Slot decode helpers.
  logic              wr_en;
  logic [CNT_W:0]    bc_inc;
  logic              bit_lt8;
  logic              rx_last;
  logic [IDX_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] buf_rd;
  logic [CMP_W-1:0]  len_w;
  logic [CNT_W-1:0]  len_sat;
  logic              scl, sda, busy, rv, rl, done;
  logic [BYTE_W-1:0] rb;

  assign bc_inc  = {1'b0, byte_count_r} + {{CNT_W{1'b0}}, 1'b1};
  assign bit_lt8 = (bit_count_r < BITS_PER_BYTE);
  assign rx_last = (bc_inc >= {1'b0, total_len_r});
  assign rd_idx  = (phase_r == PH_REG) ? '0 : bc_inc[IDX_W-1:0];
  assign buf_rd  = wbuf_r[rd_idx];
  assign len_w   = CMP_W'(item.length);
  assign len_sat = (len_w > MAX_CMP) ? MAX_CNT : CNT_W'(len_w);

  // Next state and slot outputs.
  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    sub_slot_nxt    = sub_slot_r;
    shift_nxt       = shift_r;
    byte_count_nxt  = byte_count_r;
    load_ptr_nxt    = load_ptr_r;
    total_len_nxt   = total_len_r;
    read_mode_nxt   = read_mode_r;
    last_status_nxt = last_status_r;
    ack_seen_nxt    = ack_seen_r;
    reg_latch_nxt   = reg_latch_r;
    scl             = scl_q_r;
    sda             = sda_q_r;
    busy            = 1'b1;
    rv              = 1'b0;
    rb              = '0;
    rl              = 1'b0;
    done            = 1'b0;
    wr_en           = 1'b0;

    if (phase_r == PH_IDLE) begin
      busy = 1'b0;
      scl  = 1'b1;
      sda  = 1'b1;
      case (item.cmd) inside
        CMD_LOAD: begin
          if (load_ptr_r < MAX_CNT) begin
            wr_en        = 1'b1;
            load_ptr_nxt = load_ptr_r + CNT_W'(1);
          end
        end
        CMD_WRITE, CMD_READ: begin
          read_mode_nxt = (item.cmd == CMD_READ);
          if (item.cmd == CMD_WRITE) begin
            load_ptr_nxt = '0;
          end
          reg_latch_nxt   = item.reg_addr;
          total_len_nxt   = len_sat;
          last_status_nxt = ST_OK;
          bit_count_nxt   = '0;
          sub_slot_nxt    = '0;
          byte_count_nxt  = '0;
          ack_seen_nxt    = 1'b0;
          shift_nxt       = dev_addr_r;
          phase_nxt       = PH_START_HOLD;
          busy            = 1'b1;
          scl             = 1'b1;
          sda             = 1'b0;
        end
        default: ;
      endcase
    end else if (item.cmd == CMD_TICK) begin
      unique case (phase_r) inside
        PH_START_HOLD: begin
          scl           = 1'b0;
          sda           = 1'b0;
          bit_count_nxt = '0;
          sub_slot_nxt  = '0;
          phase_nxt     = PH_DEVW;
        end
        PH_DEVW, PH_REG, PH_DATA, PH_DEVR: begin
          // Send a byte MSB first, then release SDA for the acknowledge bit.
          sda = bit_lt8 ? shift_r[BYTE_W-1] : 1'b1;
          scl = (sub_slot_r == 2'd1);
          if (sub_slot_r == 2'd1 && !bit_lt8) begin
            ack_seen_nxt = item.sda_in;
          end
          if (sub_slot_r == 2'd2) begin
            sub_slot_nxt = '0;
            if (bit_lt8) begin
              shift_nxt     = {shift_r[BYTE_W-2:0], 1'b0};
              bit_count_nxt = bit_count_r + 4'd1;
            end else begin
              bit_count_nxt = '0;
              // Decide what follows the acknowledge of this byte.
              case (phase_r)
                PH_DEVW: begin
                  if (ack_seen_r) begin
                    last_status_nxt = ST_ADDR_NACK;
                    phase_nxt       = PH_STOP1;
                  end else begin
                    shift_nxt = reg_latch_r;
                    phase_nxt = PH_REG;
                  end
                end
                PH_REG: begin
                  if (read_mode_r) begin
                    phase_nxt = PH_RS1;
                  end else if (total_len_r == '0) begin
                    phase_nxt = PH_STOP1;
                  end else begin
                    byte_count_nxt = '0;
                    shift_nxt      = buf_rd;
                    phase_nxt      = PH_DATA;
                  end
                end
                PH_DATA: begin
                  if (ack_seen_r) begin
                    last_status_nxt = ST_DATA_NACK;
                    phase_nxt       = PH_STOP1;
                  end else begin
                    byte_count_nxt = bc_inc[CNT_W-1:0];
                    if (rx_last) begin
                      phase_nxt = PH_STOP1;
                    end else begin
                      shift_nxt = buf_rd;
                    end
                  end
                end
                default: begin
                  if (ack_seen_r) begin
                    last_status_nxt = ST_ADDR_NACK;
                    phase_nxt       = PH_STOP1;
                  end else if (total_len_r == '0) begin
                    phase_nxt = PH_STOP1;
                  end else begin
                    byte_count_nxt = '0;
                    shift_nxt      = '0;
                    phase_nxt      = PH_RX;
                  end
                end
              endcase
            end
          end else begin
            sub_slot_nxt = sub_slot_r + 2'd1;
          end
        end
        PH_RX: begin
          // Sample data bits on SCL high, then ACK or NACK the byte.
          sda = bit_lt8 ? 1'b1 : rx_last;
          scl = (sub_slot_r == 2'd1);
          if (sub_slot_r == 2'd1 && bit_lt8) begin
            shift_nxt = {shift_r[BYTE_W-2:0], item.sda_in};
          end
          if (sub_slot_r == 2'd2 && !bit_lt8) begin
            rv = 1'b1;
            rb = shift_r;
            rl = rx_last;
          end
          if (sub_slot_r == 2'd2) begin
            sub_slot_nxt = '0;
            if (bit_lt8) begin
              bit_count_nxt = bit_count_r + 4'd1;
            end else begin
              bit_count_nxt  = '0;
              shift_nxt      = '0;
              byte_count_nxt = bc_inc[CNT_W-1:0];
              if (rx_last) begin
                phase_nxt = PH_STOP1;
              end
            end
          end else begin
            sub_slot_nxt = sub_slot_r + 2'd1;
          end
        end
        PH_RS1: begin
          scl       = 1'b0;
          sda       = 1'b1;
          phase_nxt = PH_RS2;
        end
        PH_RS2: begin
          scl       = 1'b1;
          sda       = 1'b1;
          phase_nxt = PH_RS3;
        end
        PH_RS3: begin
          scl       = 1'b1;
          sda       = 1'b0;
          phase_nxt = PH_RS4;
        end
        PH_RS4: begin
          scl           = 1'b0;
          sda           = 1'b0;
          shift_nxt     = dev_addr_r + 8'd1;
          bit_count_nxt = '0;
          sub_slot_nxt  = '0;
          phase_nxt     = PH_DEVR;
        end
        PH_STOP1: begin
          scl       = 1'b0;
          sda       = 1'b0;
          phase_nxt = PH_STOP2;
        end
        PH_STOP2: begin
          scl       = 1'b1;
          sda       = 1'b0;
          phase_nxt = PH_STOP3;
        end
        PH_STOP3: begin
          scl            = 1'b1;
          sda            = 1'b1;
          done           = 1'b1;
          busy           = 1'b0;
          bit_count_nxt  = '0;
          sub_slot_nxt   = '0;
          byte_count_nxt = '0;
          phase_nxt      = PH_IDLE;
        end
        default: begin
          scl       = 1'b1;
          sda       = 1'b1;
          busy      = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    scl_q_nxt = scl;
    sda_q_nxt = sda;
  end

  // Result of the current slot.
  always_comb begin
    res.scl_level = scl;
    res.sda_level = sda;
    res.busy_res  = busy;
    res.rd_valid  = rv;
    res.rd_byte   = rb;
    res.rd_last   = rl;
    res.done_res  = done;
    res.status    = last_status_nxt;
  end

  // State register, advanced once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_count_r   <= '0;
      sub_slot_r    <= '0;
      shift_r       <= '0;
      byte_count_r  <= '0;
      load_ptr_r    <= '0;
      total_len_r   <= '0;
      read_mode_r   <= 1'b0;
      last_status_r <= ST_OK;
      ack_seen_r    <= 1'b0;
      reg_latch_r   <= '0;
      scl_q_r       <= 1'b1;
      sda_q_r       <= 1'b1;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_count_r   <= bit_count_nxt;
      sub_slot_r    <= sub_slot_nxt;
      shift_r       <= shift_nxt;
      byte_count_r  <= byte_count_nxt;
      load_ptr_r    <= load_ptr_nxt;
      total_len_r   <= total_len_nxt;
      read_mode_r   <= read_mode_nxt;
      last_status_r <= last_status_nxt;
      ack_seen_r    <= ack_seen_nxt;
      reg_latch_r   <= reg_latch_nxt;
      scl_q_r       <= scl_q_nxt;
      sda_q_r       <= sda_q_nxt;
    end
  end

  // Device address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= '0;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_data;
    end
  end

  // Write buffer; entries hold garbage until loaded.
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      wbuf_r[load_ptr_r[IDX_W-1:0]] <= item.data_byte;
    end
  end

endmodule
